FILE: sv/kfs_pkg.sv
package kfs_pkg;

  typedef enum logic [2:0] {
    OP_WR_A  = 3'd0,
    OP_WR_C  = 3'd1,
    OP_WR_X  = 3'd2,
    OP_WR_P  = 3'd3,
    OP_MEAS  = 3'd4
  } kfs_op_e;

  localparam int unsigned CFG_Q = 0;
  localparam int unsigned CFG_R = 1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } kfs_in_t;

  typedef struct packed {
    logic [2:0]         element_index;
    logic signed [31:0] estimate;
    logic               last;
    logic               status;
  } kfs_out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh0000000007fffffff) r = SAT_MAX;
    else if (v < -72'sh000000000080000000) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: sv/kfs_if.sv
interface kfs_in_if;
  import kfs_pkg::*;
  logic    valid;
  logic    ready;
  kfs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/kfs_out_if.sv
interface kfs_out_if;
  import kfs_pkg::*;
  logic     valid;
  logic     ready;
  kfs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/kalman_filter_step.sv
// scalar-measurement kalman filter step, Q fixed point with saturation
// channels: in_if carries load beats (write A, C, x or P) and measurement
// beats; out_if carries DIM estimate beats per measurement, last on the
// final one, status 1 when the innovation variance was zero (state kept).
// cfg_we_i/cfg_idx_i/cfg_data_i write process noise (0) and measurement
// noise deviation (1); the user writes them only while idle, which the block does not enforce.
// a load is taken whenever the block is idle, loads can follow back to back.
// a measurement runs every product term through one shared
// multiply-accumulate unit, one term per cycle, with a store step after
// each dot product, and a divider run per gain element.
// ready is low for the whole run; one item in flight at a time, the next
// is taken in the cycle after the last estimate beat is accepted.
// a stalled receiver holds the current output beat and the sequencer waits.
// reset clears A, C, x, P, the config registers (noise deviation to 1.0)
// and all control state.
module kalman_filter_step #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfs_in_if.sink      in_if,
  kfs_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i
);
  import kfs_pkg::*;

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic signed [71:0] ONE_W = 72'sd1 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_XP, S_AP, S_PP, S_PC, S_CP, S_S, S_R, S_DIV, S_DIVW,
    S_CX, S_XU, S_IKC, S_PU, S_OUT
  } state_e;

  // storage
  logic signed [31:0] a_q   [DIM][DIM];
  logic signed [31:0] c_q   [DIM];
  logic signed [31:0] x_q   [DIM];
  logic signed [31:0] p_q   [DIM][DIM];
  logic signed [31:0] xp_q  [DIM];
  logic signed [31:0] pp_q  [DIM][DIM];
  logic signed [31:0] ap_q  [DIM][DIM];
  logic signed [31:0] k_q   [DIM];
  logic signed [31:0] pc_q  [DIM];
  logic signed [31:0] cp_q  [DIM];
  logic signed [31:0] npn_q [DIM][DIM];
  logic [30:0]        q_q, r_q;
  logic signed [31:0] s_q, e_q, y_q;

  state_e        st_q;
  logic [IW-1:0] i_q, j_q, k_q2;
  logic          wb_q;
  logic          status_q;
  logic          ov_q;
  kfs_out_t      od_q;

  // mac operands
  logic               mclr, men;
  logic signed [31:0] ma, mb;
  logic signed [71:0] minit, macc;
  logic               dstart, ddone;
  logic signed [31:0] dquo;
  logic signed [31:0] accs, s_nx;
  logic               klast, jlast, ilast, tlast, term_st;
  logic [IW-1:0]      i_nx, j_nx;
  state_e             nxt2d;

  kfs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i, .rst_ni, .clr_i(mclr), .en_i(men), .a_i(ma), .b_i(mb),
    .init_i(minit), .acc_o(macc)
  );

  kfs_div u_div (
    .clk_i, .rst_ni, .start_i(dstart),
    .num_i(64'(pc_q[i_q]) <<< FRAC_BITS), .den_i(s_q),
    .done_o(ddone), .quo_o(dquo)
  );

  assign accs    = sat32(macc);
  assign s_nx    = sat32(72'(s_q) + 72'(accs));
  assign klast   = (k_q2 == IW'(DIM - 1));
  assign jlast   = (j_q == IW'(DIM - 1));
  assign ilast   = (i_q == IW'(DIM - 1));
  assign i_nx    = i_q + IW'(1);
  assign j_nx    = j_q + IW'(1);
  assign term_st = st_q inside {S_XP, S_AP, S_PP, S_PC, S_CP, S_S, S_R, S_CX,
                                S_XU, S_IKC, S_PU};
  // single-term phases close after one product
  assign tlast   = klast || (st_q inside {S_R, S_XU, S_IKC});
  assign dstart  = (st_q == S_DIV);

  // operand select for the shared multiply-accumulate
  always_comb begin
    ma = '0; mb = '0; minit = '0;
    case (st_q)
      S_XP:  begin ma = a_q[i_q][k_q2]; mb = x_q[k_q2]; end
      S_AP:  begin ma = a_q[i_q][k_q2]; mb = p_q[k_q2][j_q]; end
      S_PP:  begin ma = ap_q[i_q][k_q2]; mb = a_q[j_q][k_q2]; end
      S_PC:  begin ma = pp_q[i_q][k_q2]; mb = c_q[k_q2]; end
      S_CP:  begin ma = c_q[k_q2]; mb = pp_q[k_q2][j_q]; end
      S_S:   begin ma = cp_q[k_q2]; mb = c_q[k_q2]; end
      S_R:   begin ma = $signed({1'b0, r_q}); mb = $signed({1'b0, r_q}); end
      S_CX:  begin ma = c_q[k_q2]; mb = xp_q[k_q2]; end
      S_XU:  begin ma = k_q[i_q]; mb = e_q; minit = 72'(xp_q[i_q]); end
      S_IKC: begin ma = k_q[i_q]; mb = c_q[j_q]; end
      S_PU:  begin ma = npn_q[i_q][k_q2]; mb = pp_q[k_q2][j_q]; end
      default: ;
    endcase
    men  = term_st && !wb_q;
    mclr = men && (k_q2 == '0);
  end

  // phase after a two-level loop
  always_comb begin
    case (st_q)
      S_AP:    nxt2d = S_PP;
      S_PP:    nxt2d = S_PC;
      S_IKC:   nxt2d = S_PU;
      default: nxt2d = S_OUT;
    endcase
  end

  // sequencer, state registers and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; i_q <= '0; j_q <= '0; k_q2 <= '0; wb_q <= 1'b0;
      status_q <= 1'b0; ov_q <= 1'b0; od_q <= '0;
      q_q <= '0; r_q <= 31'd65536;
      for (int a = 0; a < DIM; a++) begin
        c_q[a] <= '0; x_q[a] <= '0;
        for (int b = 0; b < DIM; b++) begin
          a_q[a][b] <= '0; p_q[a][b] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(CFG_Q)) q_q <= cfg_data_i;
        else r_q <= cfg_data_i;
      end
      case (st_q)
        S_IDLE: begin
          if (in_if.valid) begin
            case (in_if.data.op)
              OP_WR_A: if (32'(in_if.data.row) < DIM && 32'(in_if.data.col) < DIM)
                a_q[in_if.data.row[IW-1:0]][in_if.data.col[IW-1:0]] <= in_if.data.value;
              OP_WR_C: if (32'(in_if.data.col) < DIM)
                c_q[in_if.data.col[IW-1:0]] <= in_if.data.value;
              OP_WR_X: if (32'(in_if.data.row) < DIM)
                x_q[in_if.data.row[IW-1:0]] <= in_if.data.value;
              OP_WR_P: if (32'(in_if.data.row) < DIM && 32'(in_if.data.col) < DIM)
                p_q[in_if.data.row[IW-1:0]][in_if.data.col[IW-1:0]] <= in_if.data.value;
              OP_MEAS: begin
                st_q <= S_XP; i_q <= '0; j_q <= '0; k_q2 <= '0; wb_q <= 1'b0;
                status_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_XP, S_AP, S_PP, S_PC, S_CP, S_S, S_R, S_CX, S_XU, S_IKC, S_PU: begin
          if (!wb_q) begin
            // feed terms, then a store step
            if (tlast) begin
              wb_q <= 1'b1;
              k_q2 <= '0;
            end else begin
              k_q2 <= k_q2 + IW'(1);
            end
          end else begin
            wb_q <= 1'b0;
            case (st_q)
              S_XP: if (ilast) begin i_q <= '0; st_q <= S_AP; end else i_q <= i_nx;
              S_PC: if (ilast) begin i_q <= '0; st_q <= S_CP; end else i_q <= i_nx;
              S_XU: begin
                x_q[i_q] <= accs;
                if (ilast) begin i_q <= '0; st_q <= S_IKC; end else i_q <= i_nx;
              end
              S_CP: if (jlast) begin j_q <= '0; st_q <= S_S; end else j_q <= j_nx;
              S_S:  st_q <= S_R;
              S_R: begin
                // zero innovation variance skips the update
                if (s_nx == '0) begin
                  status_q <= 1'b1;
                  st_q     <= S_OUT;
                end else begin
                  st_q <= S_DIV;
                end
              end
              S_CX: st_q <= S_XU;
              S_AP, S_PP, S_IKC, S_PU: begin
                if (st_q == S_PU) p_q[i_q][j_q] <= accs;
                if (jlast) begin
                  j_q <= '0;
                  if (ilast) begin
                    i_q  <= '0;
                    st_q <= nxt2d;
                  end else begin
                    i_q <= i_nx;
                  end
                end else begin
                  j_q <= j_nx;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: st_q <= S_DIVW;
        S_DIVW: begin
          if (ddone) begin
            if (ilast) begin
              i_q  <= '0;
              st_q <= S_CX;
            end else begin
              i_q  <= i_nx;
              st_q <= S_DIV;
            end
          end
        end
        S_OUT: begin
          // load the first beat, then step on each accepted beat
          if (!ov_q) begin
            ov_q               <= 1'b1;
            od_q.element_index <= 3'(i_q);
            od_q.estimate      <= x_q[i_q];
            od_q.last          <= ilast;
            od_q.status        <= status_q;
          end else if (out_if.ready) begin
            if (ilast) begin
              ov_q <= 1'b0;
              i_q  <= '0;
              st_q <= S_IDLE;
            end else begin
              i_q                <= i_nx;
              od_q.element_index <= 3'(i_nx);
              od_q.estimate      <= x_q[i_nx];
              od_q.last          <= (i_nx == IW'(DIM - 1));
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // intermediate stores, written before they are read in every step
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_if.valid && in_if.data.op == OP_MEAS) y_q <= in_if.data.value;
    if (st_q == S_DIVW && ddone) k_q[i_q] <= dquo;
    if (wb_q) begin
      case (st_q)
        S_XP:  xp_q[i_q] <= accs;
        S_AP:  ap_q[i_q][j_q] <= accs;
        S_PP:  pp_q[i_q][j_q] <= (i_q == j_q) ?
                 sat32(72'(accs) + 72'($signed({1'b0, q_q}))) : accs;
        S_PC:  pc_q[i_q] <= accs;
        S_CP:  cp_q[j_q] <= accs;
        S_S:   s_q <= accs;
        S_R:   s_q <= s_nx;
        S_CX:  e_q <= sat32(72'(y_q) - 72'(accs));
        S_IKC: npn_q[i_q][j_q] <= sat32(((i_q == j_q) ? ONE_W : 72'sd0) - macc);
        default: ;
      endcase
    end
  end

  assign in_if.ready  = (st_q == S_IDLE);
  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;

endmodule

FILE: sv/kfs_mac.sv
// shared multiply-accumulate: one rounded Q product per enabled cycle into a wide sum
module kfs_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [71:0] init_i,
  output logic signed [71:0] acc_o
);
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [71:0] acc_q;
  logic signed [71:0] acc_d;

  // arithmetic shift of the biased product rounds to nearest, ties upward
  assign prod = a_i * b_i;
  assign rnd  = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  // clear with a term starts a new sum at init plus that term
  always_comb begin
    acc_d = acc_q;
    if (en_i) acc_d = (clr_i ? init_i : acc_q) + 72'(rnd);
    else if (clr_i) acc_d = init_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule

FILE: sv/kfs_div.sv
// restoring divider, one quotient bit per cycle, truncation toward zero
module kfs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import kfs_pkg::*;

  logic [63:0] n_q, n_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;
  logic signed [64:0] sq;

  assign trial = {rem_q, n_q[63]} - {2'b0, den_q};

  always_comb begin
    n_d = n_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      n_d    = num_i[63] ? 64'(-num_i) : num_i;
      den_d  = den_i[31] ? 32'(-den_i) : den_i;
      neg_d  = num_i[63] ^ den_i[31];
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], n_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      n_d   = {n_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; neg_q <= neg_d;
  end

  assign sq     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign done_o = done_q;
  assign quo_o  = sat32(72'(sq));
endmodule
